// File: hdl/matrix_vector_mac_engine_core_defines.svh
// assertion macros used by the queue (mvm_fifo)
`ifndef MATRIX_VECTOR_MAC_ENGINE_CORE_DEFINES_SVH
`define MATRIX_VECTOR_MAC_ENGINE_CORE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define MVM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define MVM_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hdl/mvm_pkg.sv
package mvm_pkg;

    localparam int MAX_DIM    = 64;
    localparam int IDX_W      = 6;
    localparam int DIM_W      = 7;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_WIDTH  = 48;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    localparam logic [1:0] MODE_LOAD_X = 2'd0;
    localparam logic [1:0] MODE_LOAD_Y = 2'd1;
    localparam logic [1:0] MODE_MAC    = 2'd2;

    localparam logic [2:0] REG_NUM_ROWS  = 3'd0;
    localparam logic [2:0] REG_NUM_COLS  = 3'd1;
    localparam logic [2:0] REG_TRANSPOSE = 3'd2;
    localparam logic [2:0] REG_ALPHA     = 3'd3;
    localparam logic [2:0] REG_BETA      = 3'd4;

    typedef struct packed {
        logic [DIM_W-1:0]             num_rows;
        logic [DIM_W-1:0]             num_cols;
        logic                         transpose;
        logic signed [DATA_WIDTH-1:0] alpha;
        logic signed [DATA_WIDTH-1:0] beta;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [IDX_W-1:0]             pos;
        logic signed [DATA_WIDTH-1:0] value;
        logic [IDX_W-1:0]             row;
        logic [IDX_W-1:0]             col;
        logic                         last_row;
        logic                         last_col;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_ACC,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_F4
    } back_state_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        else
            return v;
    endfunction

endpackage

// File: hdl/mvm_fifo.sv
`include "matrix_vector_mac_engine_core_defines.svh"
module mvm_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mvm_pkg::entry_t push_data,
    input  logic           pop,
    output mvm_pkg::entry_t pop_data,
    output logic           full,
    output logic           empty
);
    import mvm_pkg::*;

    entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `MVM_NEVER(a_count_range, clk, rst_n, count_reg > (Q_AW+1)'(Q_DEPTH), "queue count overflow")
    `MVM_ASSERT(a_push_grows, clk, rst_n, do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1, "queue push lost")
    `MVM_ASSERT(a_ptr_gap, clk, rst_n, count_reg < (Q_AW+1)'(Q_DEPTH) |-> (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_AW-1:0], "queue pointers disagree with count")

endmodule

// File: hdl/mvm_front.sv
module mvm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  mvm_pkg::cfg_t   cfg,
    input  logic            restart,
    input  logic            in_valid,
    input  logic [1:0]      in_mode,
    input  logic [5:0]      in_pos,
    input  logic [31:0]     in_value,
    output logic            in_ready,
    input  logic            q_full,
    output logic            q_push,
    output mvm_pkg::entry_t q_data
);
    import mvm_pkg::*;

    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] rows, cols;
    logic [IDX_W-1:0] r, c;
    logic             last_row, last_col, accept;

    assign rows     = eff_dim(cfg.num_rows);
    assign cols     = eff_dim(cfg.num_cols);
    assign r        = ({1'b0, row_reg} < rows) ? row_reg : '0;
    assign c        = ({1'b0, col_reg} < cols) ? col_reg : '0;
    assign last_row = ({1'b0, r} + 1'b1 == rows);
    assign last_col = ({1'b0, c} + 1'b1 == cols);
    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    // unused mode code is dropped here
    assign q_push   = accept && (in_mode == MODE_LOAD_X || in_mode == MODE_LOAD_Y
                                 || in_mode == MODE_MAC);

    always_comb
    begin
        q_data.mode     = in_mode;
        q_data.pos      = in_pos;
        q_data.value    = $signed(in_value);
        q_data.row      = r;
        q_data.col      = c;
        q_data.last_row = last_row;
        q_data.last_col = last_col;
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept && in_mode == MODE_MAC)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : r + 1'b1;
            end
            else
            begin
                col_next = c + 1'b1;
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// File: hdl/mvm_back.sv
module mvm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  mvm_pkg::cfg_t   cfg,
    input  logic            q_empty,
    input  mvm_pkg::entry_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [5:0]      out_index,
    output logic [31:0]     out_value,
    output logic            out_last
);
    import mvm_pkg::*;

    back_state_t state_reg, state_next;
    entry_t      cur_reg;

    logic signed [DATA_WIDTH-1:0]   x_mem [MAX_DIM];
    logic signed [DATA_WIDTH-1:0]   y_mem [MAX_DIM];
    logic signed [ACC_WIDTH-1:0]    cs_mem [MAX_DIM];
    logic signed [DATA_WIDTH-1:0]   x_rd_reg, y_rd_reg;
    logic signed [ACC_WIDTH-1:0]    cs_rd_reg;
    logic signed [2*DATA_WIDTH-1:0] prod_reg;
    logic signed [ACC_WIDTH-1:0]    row_sum_reg, sum_reg;
    logic signed [2*DATA_WIDTH-1:0] pa_reg, pc_reg;
    logic signed [DATA_WIDTH+FRAC_BITS:0] pb_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]               out_index_reg;
    logic [DATA_WIDTH-1:0]          out_value_reg;
    logic                           out_last_reg;

    logic [IDX_W-1:0]               x_addr, y_addr;
    logic                           emit, first, out_load;
    logic signed [2*DATA_WIDTH-1:0] prod_rnd;
    logic signed [ACC_WIDTH-1:0]    p, base, s;
    logic signed [ACC_WIDTH:0]      s_wide;
    logic signed [DATA_WIDTH-1:0]   sum_hi;
    logic signed [FRAC_BITS:0]      sum_lo;
    logic signed [DATA_WIDTH+FRAC_BITS:0] pb_rnd;
    logic signed [2*DATA_WIDTH-1:0] pc_rnd;
    logic signed [2*DATA_WIDTH+1:0] total;
    logic signed [DATA_WIDTH-1:0]   res;

    localparam logic signed [ACC_WIDTH:0] ACC_HI = (ACC_WIDTH+1)'((64'sd1 <<< (ACC_WIDTH-1)) - 1);
    localparam logic signed [ACC_WIDTH:0] ACC_LO = -ACC_HI - 1;
    localparam logic signed [2*DATA_WIDTH+1:0] RES_HI =
        (2*DATA_WIDTH+2)'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
    localparam logic signed [2*DATA_WIDTH+1:0] RES_LO = -RES_HI - 1;

    // address selection by orientation
    assign x_addr = cfg.transpose ? cur_reg.row : cur_reg.col;
    assign y_addr = cfg.transpose ? cur_reg.col : cur_reg.row;
    assign emit   = cfg.transpose ? cur_reg.last_row : cur_reg.last_col;
    assign first  = cfg.transpose ? (cur_reg.row == '0) : (cur_reg.col == '0);

    // product rounded half up to q.16, sum saturated to 48 bits
    assign prod_rnd = (prod_reg + (2*DATA_WIDTH)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
    assign p        = prod_rnd[ACC_WIDTH-1:0];
    assign base     = cfg.transpose ? cs_rd_reg : row_sum_reg;
    assign s_wide   = {base[ACC_WIDTH-1], base} + {p[ACC_WIDTH-1], p};
    always_comb
    begin
        if (first)
            s = p;
        else if (s_wide > ACC_HI)
            s = ACC_HI[ACC_WIDTH-1:0];
        else if (s_wide < ACC_LO)
            s = ACC_LO[ACC_WIDTH-1:0];
        else
            s = s_wide[ACC_WIDTH-1:0];
    end

    // alpha*sum split into integer and fraction parts
    assign sum_hi = sum_reg[ACC_WIDTH-1:FRAC_BITS];
    assign sum_lo = $signed({1'b0, sum_reg[FRAC_BITS-1:0]});
    assign pb_rnd = (pb_reg + (DATA_WIDTH+FRAC_BITS+1)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
    assign pc_rnd = (pc_reg + (2*DATA_WIDTH)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
    assign total  = (2*DATA_WIDTH+2)'(pa_reg) + (2*DATA_WIDTH+2)'(pb_rnd)
                  + (2*DATA_WIDTH+2)'(pc_rnd);
    always_comb
    begin
        if (total > RES_HI)
            res = RES_HI[DATA_WIDTH-1:0];
        else if (total < RES_LO)
            res = RES_LO[DATA_WIDTH-1:0];
        else
            res = total[DATA_WIDTH-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_EXEC;
            ST_EXEC: state_next = (cur_reg.mode == MODE_MAC) ? ST_MUL : ST_IDLE;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = emit ? ST_F1 : ST_IDLE;
            ST_F1:   state_next = ST_F2;
            ST_F2:   state_next = ST_F3;
            ST_F3:   state_next = ST_F4;
            ST_F4:   if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop = !q_empty;
            ST_F4:   out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC && cur_reg.mode == MODE_LOAD_X)
            x_mem[cur_reg.pos] <= cur_reg.value;
        x_rd_reg <= x_mem[x_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC && cur_reg.mode == MODE_LOAD_Y)
            y_mem[cur_reg.pos] <= cur_reg.value;
        y_rd_reg <= y_mem[y_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACC && cfg.transpose)
            cs_mem[cur_reg.col] <= s;
        cs_rd_reg <= cs_mem[cur_reg.col];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
        if (state_reg == ST_MUL)
            prod_reg <= cur_reg.value * x_rd_reg;
        if (state_reg == ST_ACC)
        begin
            sum_reg     <= s;
            row_sum_reg <= s;
        end
        if (state_reg == ST_F1)
            pa_reg <= cfg.alpha * sum_hi;
        if (state_reg == ST_F2)
            pb_reg <= cfg.alpha * sum_lo;
        if (state_reg == ST_F3)
            pc_reg <= cfg.beta * y_rd_reg;
        if (out_load)
        begin
            out_index_reg <= cfg.transpose ? cur_reg.col : cur_reg.row;
            out_value_reg <= res;
            out_last_reg  <= cur_reg.last_row && cur_reg.last_col;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

// File: hdl/matrix_vector_mac_engine_core.sv
// sequence: a load word passes back end states IDLE (pop) and EXEC (store), a
// matrix word IDLE, EXEC, MUL and ACC, and one that finishes a y element then
// F1 to F4, F4 waiting until the output register is free to take the result
// throughput: one queued word at a time in the back end, set by the multiply
// sequence; the front takes a word per cycle into a 4-deep queue unless full
// reset: rst_n is asynchronous and active low, clears counters, queue and control
module matrix_vector_mac_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[5:0], element_value[37:6], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_index[5:0], out_value[37:6], zero pad
    output logic        m_tlast    // final_res
);
    import mvm_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   restart;
    logic   q_push, q_pop, q_full, q_empty;
    entry_t q_in, q_out;
    logic [5:0]  out_index;
    logic [31:0] out_value;

    // a dimension or orientation write restarts the matrix stream
    assign restart = cfg_we && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS
                                || cfg_index == REG_TRANSPOSE);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_ROWS:  cfg_next.num_rows  = cfg_data[DIM_W-1:0];
                REG_NUM_COLS:  cfg_next.num_cols  = cfg_data[DIM_W-1:0];
                REG_TRANSPOSE: cfg_next.transpose = cfg_data[0];
                REG_ALPHA:     cfg_next.alpha     = $signed(cfg_data);
                REG_BETA:      cfg_next.beta      = $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_rows  <= DIM_W'(1);
            cfg_reg.num_cols  <= DIM_W'(1);
            cfg_reg.transpose <= 1'b0;
            cfg_reg.alpha     <= DATA_WIDTH'(1 << FRAC_BITS);   // 1.0
            cfg_reg.beta      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accepts words and tags matrix words with row and column
    mvm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .restart  (restart),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_pos   (s_tdata[5:0]),
        .in_value (s_tdata[37:6]),
        .in_ready (s_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // queue decouples the front from the multiply sequence
    mvm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: stores, multiply-accumulate, scaling and output register
    mvm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_value, out_index};

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mvm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 50;
    localparam int LONG_HOLD = 500;

    typedef struct {
        logic [1:0]  mode;
        logic [5:0]  pos;
        logic [31:0] value;
    } in_word_t;

    typedef struct {
        logic [5:0]  idx;
        logic [31:0] value;
        logic        fin;
    } y_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // position[5:0], element_value[37:6], zero pad
    logic [1:0]  s_tuser = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // out_index[5:0], out_value[37:6], zero pad
    logic        m_tlast;        // final_res

    matrix_vector_mac_engine_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------
    // gemv predictor: own copy of the vectors, sums and settings
    // ------------------------------------------------------------------
    longint    x_vec [MAX_DIM];
    longint    y_old [MAX_DIM];
    longint    col_acc [MAX_DIM];
    longint    row_acc = 0;
    int        row_pos = 0;
    int        col_pos = 0;
    int        rows_reg = 1;
    int        cols_reg = 1;
    bit        trans_reg = 1'b0;
    longint    alpha_q = 64'sd65536;   // 1.0 after reset
    longint    beta_q = 0;

    in_word_t  pending_words[$];
    y_word_t   expected_y[$];
    int        errors = 0;
    int        results_seen = 0;
    int        queued = 0;
    bit        no_gaps = 1'b0;   // sender and receiver run without random gaps when set

    // round a Q32.32 product to Q.16, half up
    function automatic longint round_q16(longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic int dim_used(int v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    // alpha*sum (integer part exact, fraction part rounded) + beta*old rounded, then clipped to the data width
    function automatic longint scale_y(longint sum, longint old);
        longint hi;
        longint lo;
        longint t1;
        hi = sum >>> 16;
        lo = sum & 64'hFFFF;
        t1 = alpha_q * hi + round_q16(alpha_q * lo);
        return clip(t1 + round_q16(beta_q * old), DATA_WIDTH);
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_NUM_ROWS:  rows_reg = int'(v[6:0]);
            REG_NUM_COLS:  cols_reg = int'(v[6:0]);
            REG_TRANSPOSE: trans_reg = v[0];
            REG_ALPHA:     alpha_q = longint'(signed'(v));
            REG_BETA:      beta_q = longint'(signed'(v));
            default: ;
        endcase
        // a dimension or transpose write restarts the matrix stream
        if (idx == REG_NUM_ROWS || idx == REG_NUM_COLS || idx == REG_TRANSPOSE) begin
            row_pos = 0;
            col_pos = 0;
            row_acc = 0;
        end
    endfunction

    function automatic void gemv_step(in_word_t w);
        longint  v;
        longint  p;
        longint  s;
        longint  t;
        int      nr;
        int      nc;
        int      r;
        int      c;
        bit      lc;
        bit      lr;
        y_word_t y;
        v = longint'(signed'(w.value));
        if (w.mode == MODE_LOAD_X) begin
            x_vec[w.pos] = v;
            return;
        end
        if (w.mode == MODE_LOAD_Y) begin
            y_old[w.pos] = v;
            return;
        end
        if (w.mode != MODE_MAC)
            return;
        nr = dim_used(rows_reg);
        nc = dim_used(cols_reg);
        r = (row_pos < nr) ? row_pos : 0;
        c = (col_pos < nc) ? col_pos : 0;
        lc = (c + 1 == nc);
        lr = (r + 1 == nr);
        if (!trans_reg) begin
            p = round_q16(v * x_vec[c]);
            s = (c == 0) ? p : clip(row_acc + p, ACC_WIDTH);
            row_acc = s;
            if (lc) begin
                y.idx = r[5:0];
                t = scale_y(row_acc, y_old[r]);
                y.value = t[31:0];
                y.fin = lr;
                expected_y.push_back(y);
                row_acc = 0;
            end
        end else begin
            p = round_q16(v * x_vec[r]);
            s = (r == 0) ? p : clip(col_acc[c] + p, ACC_WIDTH);
            col_acc[c] = s;
            if (lr) begin
                y.idx = c[5:0];
                t = scale_y(s, y_old[c]);
                y.value = t[31:0];
                y.fin = lc;
                expected_y.push_back(y);
            end
        end
        if (lc) begin
            col_pos = 0;
            row_pos = lr ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    // ------------------------------------------------------------------
    // clock, reset, watchdog
    // ------------------------------------------------------------------
    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    int cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("matrix_vector_mac_engine_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sender: pops pending words, random gap after each
    // ------------------------------------------------------------------
    int tx_gap = 0;
    always @(posedge clk or negedge rst_n) begin : sender
        in_word_t w;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            // a word is taken at this edge: predict its effect in order
            if (s_tvalid && s_tready) begin
                w.mode = s_tuser;
                w.pos = s_tdata[5:0];
                w.value = s_tdata[37:6];
                gemv_step(w);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    w = pending_words.pop_front();
                    s_tdata <= {2'b00, w.value, w.pos};
                    s_tuser <= w.mode;
                    s_tvalid <= 1'b1;
                    tx_gap <= no_gaps ? 0 : $urandom_range(0, 14);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: checks each result, random stalls, one long hold-off
    // ------------------------------------------------------------------
    int rx_wait = 0;
    int hold_left = 0;
    always @(posedge clk or negedge rst_n) begin : receiver
        y_word_t e;
        bit      took;
        int      w;
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
            hold_left <= 0;
        end else begin
            took = m_tvalid && m_tready;
            if (took) begin
                results_seen <= results_seen + 1;
                if (expected_y.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: result with nothing expected: idx %0d value %h last %b",
                             $time, m_tdata[5:0], m_tdata[37:6], m_tlast);
                end else begin
                    e = expected_y.pop_front();
                    if (m_tdata[5:0] !== e.idx) begin
                        errors = errors + 1;
                        $display("%0t: out_index expected %0d actual %0d",
                                 $time, e.idx, m_tdata[5:0]);
                    end
                    if (m_tdata[37:6] !== e.value) begin
                        errors = errors + 1;
                        $display("%0t: out_value expected %h actual %h",
                                 $time, e.value, m_tdata[37:6]);
                    end
                    if (m_tlast !== e.fin) begin
                        errors = errors + 1;
                        $display("%0t: final_res expected %b actual %b",
                                 $time, e.fin, m_tlast);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= (hold_left == 1);
            end else if (took && results_seen == 40) begin
                // long stall so the input queue backs up
                hold_left <= LONG_HOLD;
                m_tready <= 1'b0;
            end else if (took) begin
                w = no_gaps ? 0 : $urandom_range(0, 14);
                rx_wait <= w;
                m_tready <= (w == 0);
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_word(logic [1:0] m, logic [5:0] p, logic [31:0] v);
        in_word_t w;
        w.mode = m;
        w.pos = p;
        w.value = v;
        pending_words.push_back(w);
        queued = queued + 1;
    endfunction

    // wait until every word is sent and every y element has come back
    task automatic wait_quiet();
        @(posedge clk);
        while (pending_words.size() > 0 || s_tvalid || expected_y.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        apply_reg(idx, v);
    endtask

    task automatic setup(int nr, int nc, bit tr, logic [31:0] a, logic [31:0] b);
        wait_quiet();
        write_reg(REG_NUM_ROWS, 32'(nr));
        write_reg(REG_NUM_COLS, 32'(nc));
        write_reg(REG_TRANSPOSE, 32'(tr));
        write_reg(REG_ALPHA, a);
        write_reg(REG_BETA, b);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // fresh vectors for the active sizes, then the matrix stream, with noise when noisy is set
    task automatic queue_matrix(int n_mac, bit noisy);
        int nr;
        int nc;
        int xl;
        int yl;
        nr = dim_used(rows_reg);
        nc = dim_used(cols_reg);
        xl = trans_reg ? nr : nc;
        yl = trans_reg ? nc : nr;
        for (int i = 0; i < xl; i++)
            queue_word(MODE_LOAD_X, 6'(i), pick_value());
        for (int i = 0; i < yl; i++)
            queue_word(MODE_LOAD_Y, 6'(i), pick_value());
        for (int i = 0; i < n_mac; i++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                queue_word(logic'($urandom_range(0, 1)) ? MODE_UNUSED : 2'($urandom_range(0, 1)),
                           6'($urandom_range(0, 63)), pick_value());
            queue_word(MODE_MAC, 6'($urandom_range(0, 63)), pick_value());
        end
    endtask

    int nr;
    int nc;
    int n_mac;

    initial begin
        @(posedge rst_n);
        // every store entry gets a value before any is read
        for (int i = 0; i < MAX_DIM; i++) begin
            queue_word(MODE_LOAD_X, 6'(i), pick_value());
            queue_word(MODE_LOAD_Y, 6'(i), pick_value());
        end

        // directed: reset settings, extremes, unused mode, odd dimensions
        queue_word(MODE_MAC, 6'd0, 32'h7FFF_FFFF);
        queue_word(MODE_UNUSED, 6'h3F, 32'hFFFF_FFFF);
        queue_word(MODE_MAC, 6'h3F, 32'h8000_0000);
        setup(2, 3, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_word(MODE_LOAD_X, 6'd0, 32'h7FFF_FFFF);
        queue_word(MODE_LOAD_X, 6'd1, 32'h8000_0000);
        queue_word(MODE_LOAD_X, 6'd2, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++)
            queue_word(MODE_MAC, 6'(i), (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
        setup(3, 2, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++)
            queue_word(MODE_MAC, 6'(i), 32'h8000_0000);
        // zero dimension acts as one, oversize acts as the maximum
        setup(0, 127, 1'b0, 32'h0001_0000, 32'h0000_8000);
        queue_matrix(MAX_DIM, 1'b0);
        setup(127, 0, 1'b1, 32'hFFFF_0000, 32'h0000_0000);
        queue_matrix(MAX_DIM, 1'b0);
        // scale change between elements of one operation
        setup(2, 2, 1'b0, 32'h0002_0000, 32'h0001_0000);
        queue_matrix(2, 1'b0);
        wait_quiet();
        write_reg(REG_ALPHA, 32'hFFFE_8000);
        write_reg(REG_BETA, 32'h0000_0001);
        @(posedge clk);
        cfg_we <= 1'b0;
        queue_matrix(2, 1'b0);

        // random phases: mostly small shapes, whole operations unless capped, plus sometimes a broken tail
        while (queued < 1300) begin
            nr = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            nc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            if ($urandom_range(0, 15) == 0)
                nr = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
            setup(nr, nc, 1'($urandom_range(0, 1)), pick_value(), pick_value());
            no_gaps = ($urandom_range(0, 3) == 0);
            n_mac = dim_used(nr) * dim_used(nc) * $urandom_range(1, 3);
            if (n_mac > 300)
                n_mac = 300;
            if ($urandom_range(0, 3) == 0)
                n_mac += $urandom_range(1, 5);
            queue_matrix(n_mac, 1'b1);
        end

        wait_quiet();
        if (errors == 0)
            $display("matrix_vector_mac_engine_core test passed");
        else
            $display("matrix_vector_mac_engine_core test failed");
        $finish;
    end

endmodule
